/* rtl/interval_graph_greedy_coloring_macros.svh */
// assertion macros for the interval coloring block
`ifndef INTERVAL_GRAPH_GREEDY_COLORING_MACROS_SVH
`define INTERVAL_GRAPH_GREEDY_COLORING_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define IGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define IGC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/igc_pkg.sv */
// ---------------------------------------------------------------------------
// igc_pkg
// types, constants and sequencer states for the interval coloring block
// ---------------------------------------------------------------------------
package igc_pkg;

	// set capacity and coordinate width
	localparam int unsigned MAX_INTERVALS = 32;
	localparam int unsigned COORD_WIDTH = 16;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_point;
		logic signed [COORD_WIDTH-1:0] end_point;
		logic                          final_item;
	} igc_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_out;
		logic signed [COORD_WIDTH-1:0] end_out;
		logic [5:0]         color;
		logic [4:0]         degree;
		logic [8:0]         edge_count;
		logic [4:0]         max_degree;
		logic [4:0]         min_degree;
		logic [5:0]         color_count;
		logic [8:0]         comp_edge_count;
		logic [4:0]         comp_max_degree;
		logic [4:0]         comp_min_degree;
		logic               final_result;
	} igc_out_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_WR,
		ST_PAIR,
		ST_STAT,
		ST_COLOR,
		ST_COLOR_PICK,
		ST_EMIT
	} igc_state_t;

endpackage

/* rtl/igc_cmp.sv */
// ---------------------------------------------------------------------------
// igc_cmp
// shared overlap comparator: ordering and adjacency of two intervals
// ---------------------------------------------------------------------------
module igc_cmp import igc_pkg::*; #(
	parameter int unsigned CW = 16
) (
	input  logic signed [CW-1:0] sa,
	input  logic signed [CW-1:0] ea,
	input  logic signed [CW-1:0] sb,
	input  logic signed [CW-1:0] eb,
	output logic                 a_gt_b,
	output logic                 adj
);
	// later start must lie at or before the earlier end
	always_comb begin
		a_gt_b = (sa > sb);
		if (sa < sb)
			adj = (sb <= ea);
		else if (sa > sb)
			adj = (sa <= eb);
		else
			adj = 1'b1;
	end
endmodule

/* rtl/interval_graph_greedy_coloring.sv */
// ---------------------------------------------------------------------------
// interval_graph_greedy_coloring
// collects intervals, sorts them, builds overlap statistics and colors them
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one interval per transfer; the
// transfer with final_item set closes the set (intervals beyond
// MAX_INTERVALS are dropped, their final bit still counts).
// Output channel: out_valid/out_stall deliver one result per stored
// interval in sorted order, final_result on the last one.
// Processing of a set: loading, then an insertion sort of the stored
// intervals, a pass over all pairs for degrees, a statistics pass and a
// greedy coloring pass, the sort, pair and coloring passes sharing one
// comparator; then the result transfers and a return to loading.
// in_stall is high from the final transfer until the last result leaves.
// A stalled receiver simply holds the current result in its register.
// Reset clears the sequencer and the item count; stores are not cleared.
// ---------------------------------------------------------------------------
module interval_graph_greedy_coloring import igc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  igc_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output igc_out_t out_data
);
	localparam int unsigned IW = $clog2(MAX_INTERVALS);
	localparam int unsigned NW = $clog2(MAX_INTERVALS + 1);
	localparam int unsigned CUW = $clog2(MAX_INTERVALS + 2);

	logic signed [COORD_WIDTH-1:0] start_mem [MAX_INTERVALS];
	logic signed [COORD_WIDTH-1:0] end_mem [MAX_INTERVALS];
	logic [5:0] color_mem [MAX_INTERVALS];
	logic [5:0] degree_mem [MAX_INTERVALS];

	igc_state_t state_q, state_d;
	logic [NW-1:0] n_q, i_q, j_q;
	logic [5:0] colors_q;
	logic [10:0] total_q;
	logic [5:0] dmax_q, dmin_q;
	logic [MAX_INTERVALS+1:0] used_q;
	logic signed [COORD_WIDTH-1:0] ks_q, ke_q;
	logic out_valid_q;
	igc_out_t out_q;

	logic signed [COORD_WIDTH-1:0] sa, ea, sb, eb;
	logic gt, adj;
	logic [IW-1:0] ia, ib;
	logic accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_LOAD);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// operand selection for the shared comparator
	always_comb begin
		ia = i_q[IW-1:0];
		ib = j_q[IW-1:0];
		sa = start_mem[ia];
		ea = end_mem[ia];
		sb = start_mem[ib];
		eb = end_mem[ib];
		if (state_q == ST_SORT_CMP) begin
			ib = IW'(j_q - NW'(1));
			sa = start_mem[ib];
			ea = end_mem[ib];
			sb = ks_q;
			eb = ke_q;
		end
	end

	igc_cmp #(.CW(COORD_WIDTH)) u_cmp (
		.sa(sa), .ea(ea), .sb(sb), .eb(eb), .a_gt_b(gt), .adj(adj)
	);

	// first free color in the used mask
	logic [5:0] pick;
	always_comb begin
		pick = 6'(MAX_INTERVALS + 1);
		for (int k = MAX_INTERVALS; k >= 1; k--)
			if (!used_q[k]) pick = 6'(k);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:
				if (accept && in_data.final_item) state_d = ST_SORT_RD;
			ST_SORT_RD:
				if (i_q >= n_q) state_d = ST_PAIR;
				else state_d = ST_SORT_CMP;
			ST_SORT_CMP:
				if (j_q == '0 || !gt) state_d = ST_SORT_WR;
			ST_SORT_WR: state_d = ST_SORT_RD;
			ST_PAIR:
				if (i_q + NW'(1) >= n_q) state_d = ST_STAT;
			ST_STAT:
				if (i_q + NW'(1) >= n_q) state_d = ST_COLOR;
			ST_COLOR:
				if (i_q >= n_q) state_d = ST_EMIT;
				else if (j_q >= i_q) state_d = ST_COLOR_PICK;
			ST_COLOR_PICK: state_d = ST_COLOR;
			ST_EMIT:
				if (i_q >= n_q && !(out_valid_q && out_stall)) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// sequencer counters and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			colors_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (n_q < NW'(MAX_INTERVALS)) n_q <= n_q + NW'(1);
						i_q <= NW'(1);
					end
				end
				ST_SORT_RD: begin
					j_q <= i_q;
					if (i_q >= n_q) begin
						i_q <= '0;
						j_q <= NW'(1);
					end
				end
				ST_SORT_CMP:
					if (j_q != '0 && gt) j_q <= j_q - NW'(1);
				ST_SORT_WR: i_q <= i_q + NW'(1);
				ST_PAIR: begin
					if (j_q + NW'(1) >= n_q) begin
						i_q <= i_q + NW'(1);
						j_q <= i_q + NW'(2);
					end else j_q <= j_q + NW'(1);
					if (i_q + NW'(1) >= n_q) i_q <= '0;
				end
				ST_STAT: begin
					i_q <= i_q + NW'(1);
					if (i_q + NW'(1) >= n_q) begin
						i_q <= '0;
						j_q <= '0;
						colors_q <= 6'd1;
					end
				end
				ST_COLOR: begin
					// restart the index for the result pass
					if (i_q >= n_q) i_q <= '0;
					else if (j_q < i_q) j_q <= j_q + NW'(1);
				end
				ST_COLOR_PICK: begin
					if (pick > colors_q) colors_q <= pick;
					i_q <= i_q + NW'(1);
					j_q <= '0;
				end
				ST_EMIT: begin
					if (!(out_valid_q && out_stall)) begin
						out_valid_q <= (i_q < n_q);
						if (i_q < n_q) i_q <= i_q + NW'(1);
						else begin
							n_q <= '0;
							i_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// degree sums and extremes
	always_ff @(posedge clk) begin
		if (state_q == ST_PAIR && i_q == '0 && j_q == NW'(1)) begin
			total_q <= '0;
			dmax_q <= '0;
			dmin_q <= 6'(n_q - NW'(1));
		end
		if (state_q == ST_STAT) begin
			total_q <= total_q + 11'(degree_mem[ia]);
			if (degree_mem[ia] > dmax_q) dmax_q <= degree_mem[ia];
			if (degree_mem[ia] < dmin_q) dmin_q <= degree_mem[ia];
		end
		if (state_q == ST_SORT_RD && i_q >= n_q) begin
			total_q <= '0;
			dmax_q <= '0;
			dmin_q <= 6'(n_q - NW'(1));
		end
	end

	// used-color mask
	always_ff @(posedge clk) begin
		if (state_q == ST_COLOR && j_q < i_q) begin
			if (adj && color_mem[ib] <= 6'(MAX_INTERVALS))
				used_q[CUW'(color_mem[ib])] <= 1'b1;
		end else if (state_q != ST_COLOR) used_q <= '0;
	end

	// storage writes
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && accept && n_q < NW'(MAX_INTERVALS)) begin
			start_mem[n_q[IW-1:0]] <= COORD_WIDTH'(in_data.start_point);
			end_mem[n_q[IW-1:0]] <= COORD_WIDTH'(in_data.end_point);
		end
		if (state_q == ST_SORT_RD && i_q < n_q) begin
			ks_q <= start_mem[ia];
			ke_q <= end_mem[ia];
		end
		if (state_q == ST_SORT_CMP && j_q != '0 && gt) begin
			start_mem[j_q[IW-1:0]] <= start_mem[ib];
			end_mem[j_q[IW-1:0]] <= end_mem[ib];
		end
		if (state_q == ST_SORT_WR) begin
			start_mem[j_q[IW-1:0]] <= ks_q;
			end_mem[j_q[IW-1:0]] <= ke_q;
		end
		if (state_q == ST_SORT_RD && i_q >= n_q)
			for (int k = 0; k < MAX_INTERVALS; k++) degree_mem[k] <= '0;
		if (state_q == ST_PAIR && j_q < n_q && adj) begin
			degree_mem[ia] <= degree_mem[ia] + 6'd1;
			degree_mem[ib] <= degree_mem[ib] + 6'd1;
		end
		if (state_q == ST_COLOR_PICK) color_mem[ia] <= pick;
	end

	// result register
	logic [11:0] pairs;
	assign pairs = (12'(n_q) * 12'(n_q - NW'(1))) >> 1;
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && !(out_valid_q && out_stall) && i_q < n_q) begin
			out_q.start_out <= COORD_WIDTH'(start_mem[ia]);
			out_q.end_out <= COORD_WIDTH'(end_mem[ia]);
			out_q.color <= color_mem[ia];
			out_q.degree <= 5'(degree_mem[ia]);
			out_q.edge_count <= 9'(total_q >> 1);
			out_q.max_degree <= 5'(dmax_q);
			out_q.min_degree <= 5'(dmin_q);
			out_q.color_count <= colors_q;
			out_q.comp_edge_count <= 9'(pairs - 12'(total_q >> 1));
			out_q.comp_max_degree <= 5'(6'(n_q - NW'(1)) - dmin_q);
			out_q.comp_min_degree <= 5'(6'(n_q - NW'(1)) - dmax_q);
			out_q.final_result <= (i_q + NW'(1) == n_q);
		end
	end
endmodule

/* rtl/igc_checker.sv */
// ---------------------------------------------------------------------------
// igc_checker
// port-level checks for the interval coloring block
// ---------------------------------------------------------------------------
`include "interval_graph_greedy_coloring_macros.svh"
module igc_checker import igc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input igc_in_t  in_data,
	input logic     out_valid,
	input logic     out_stall,
	input igc_out_t out_data
);
	`IGC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
	`IGC_ASSERT_IMP(a_no_out_while_load, clk, arst_n, out_valid, in_stall, "result shown while loading")
	`IGC_ASSERT_IMP(a_color_range, clk, arst_n, out_valid, out_data.color != 6'd0 && out_data.color <= out_data.color_count, "color out of range")
	`IGC_ASSERT_NXT(a_final_busy, clk, arst_n, in_valid && !in_stall && in_data.final_item, in_stall, "final transfer did not start work")
endmodule

bind interval_graph_greedy_coloring igc_checker u_igc_checker (.*);
